/* rtl/core/wpsb_pkg.sv */
// shared constants and helpers for the phosphate sorption balance pipeline
package wpsb_pkg;

    localparam int VALUE_WIDTH_DEF = 48;
    localparam int CONC_W          = 32;
    localparam int RATE_W          = 25;
    localparam int SHARE_W         = 17;
    localparam int CS_W            = 51;
    localparam int SHARE_BITS      = 16;
    localparam int CONC_BITS       = 16;
    localparam int RATE_BITS       = 24;
    localparam int LIMB_W          = 32;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SUSP_FOREST,
        REG_SUSP_GRASS,
        REG_SUSP_CROP,
        REG_MAX_SORPTION,
        REG_HALF_SAT
    } cfg_reg_t;

    function automatic int limbs(input int w);
        return (w + LIMB_W - 1) / LIMB_W;
    endfunction

    function automatic int max2(input int x, input int y);
        return (x > y) ? x : y;
    endfunction

    // common latency of every product unit, set by the widest product
    function automatic int mul_latency(input int w);
        int m;
        m = limbs(w) * limbs(RATE_W);
        m = max2(m, limbs(CONC_W) * limbs(w));
        m = max2(m, limbs(w + RATE_W) * limbs(CS_W));
        m = max2(m, limbs(w + 21) * limbs(w + 21));
        m = max2(m, limbs(w + 16) * limbs(w + 1));
        m = max2(m, 2);
        return 1 + $clog2(m);
    endfunction

endpackage

/* rtl/core/water_phosphate_sorption_balance.sv */
// top level: phosphate sorption equilibrium pipeline with configuration registers
// throughput: one transaction per cycle unless the output stalls; the square root stages
//   (one root bit each) set depth
// a stalled output holds the whole pipeline; reset clears valid bits and configuration
module water_phosphate_sorption_balance #(
    parameter int VALUE_WIDTH = wpsb_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [wpsb_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [wpsb_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [VALUE_WIDTH-1:0]                water_volume,
    input  logic [VALUE_WIDTH-1:0]                free_phosphate,
    input  logic [VALUE_WIDTH-1:0]                bound_phosphate,
    input  logic [wpsb_pkg::SHARE_W-1:0]          forest_fraction,
    input  logic [wpsb_pkg::SHARE_W-1:0]          grass_fraction,
    input  logic [wpsb_pkg::SHARE_W-1:0]          crop_fraction,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [VALUE_WIDTH-1:0]                new_free_phosphate,
    output logic [VALUE_WIDTH-1:0]                new_bound_phosphate,
    output logic                                  skipped
);

    localparam int W      = VALUE_WIDTH;
    localparam int CS_W   = wpsb_pkg::CS_W;
    localparam int CONC_W = wpsb_pkg::CONC_W;
    localparam int RATE_W = wpsb_pkg::RATE_W;
    localparam int SH_W   = wpsb_pkg::SHARE_W;
    localparam int TOT_W  = W + 1;
    localparam int VR_W   = W + RATE_W;
    localparam int SB_PW  = VR_W + CS_W;
    localparam int SB_SH  = wpsb_pkg::SHARE_BITS + wpsb_pkg::CONC_BITS + wpsb_pkg::RATE_BITS;
    localparam int KV_PW  = CONC_W + W;
    localparam int KV_W   = KV_PW - wpsb_pkg::CONC_BITS;
    localparam int P_W    = W + 21;
    localparam int BB_PW  = 2 * P_W;
    localparam int KT_PW  = KV_W + TOT_W;
    localparam int D_W    = BB_PW + 1;
    localparam int RW     = (D_W + 1) / 2;
    localparam int LM     = wpsb_pkg::mul_latency(W);

    localparam int S_CS = 2;
    localparam int S_KV = LM + 1;
    localparam int S_PA = 2 * LM + 1;
    localparam int S_P  = 2 * LM + 2;
    localparam int S_D  = S_P + LM + 1;
    localparam int S_F  = S_D + RW + 1;

    typedef struct packed {
        logic [W-1:0]     fp;
        logic [W-1:0]     bp;
        logic [TOT_W-1:0] tot;
        logic             skip;
        logic [CS_W-1:0]  cs;
        logic [KV_W-1:0]  kv;
        logic [P_W-1:0]   p;
        logic [P_W-1:0]   b;
        logic             neg;
        logic [RW-1:0]    f;
    } side_t;

    logic [CONC_W-1:0] conc_forest_reg;
    logic [CONC_W-1:0] conc_grass_reg;
    logic [CONC_W-1:0] conc_crop_reg;
    logic [RATE_W-1:0] rate_reg;
    logic [CONC_W-1:0] half_sat_reg;

    logic              en;
    logic [S_F:0]      valid_reg;
    logic              out_valid_reg;
    logic [W-1:0]      new_free_reg;
    logic [W-1:0]      new_bound_reg;
    logic              skipped_reg;

    logic [W-1:0]      vol_reg;
    logic [SH_W-1:0]   share_reg [0:2];
    logic [SH_W+CONC_W-1:0] cprod_reg [0:2];

    side_t             side_reg  [0:S_F];
    side_t             side_next [0:S_F];

    logic [VR_W-1:0]   vr_prod;
    logic [KV_PW-1:0]  kv_prod;
    logic [SB_PW-1:0]  sb_prod;
    logic [BB_PW-1:0]  bb_prod;
    logic [KT_PW-1:0]  kt_prod;
    logic [D_W-1:0]    d_reg;
    logic [RW-1:0]     root;

    logic [W-1:0]      free_out;
    logic [W-1:0]      bound_out;
    logic [TOT_W-1:0]  f_clamp;
    logic [TOT_W-1:0]  g_val;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conc_forest_reg <= '0;
            conc_grass_reg  <= '0;
            conc_crop_reg   <= '0;
            rate_reg        <= '0;
            half_sat_reg    <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (wpsb_pkg::cfg_reg_t'(cfg_index))
                wpsb_pkg::REG_SUSP_FOREST:  conc_forest_reg <= cfg_data[CONC_W-1:0];
                wpsb_pkg::REG_SUSP_GRASS:   conc_grass_reg  <= cfg_data[CONC_W-1:0];
                wpsb_pkg::REG_SUSP_CROP:    conc_crop_reg   <= cfg_data[CONC_W-1:0];
                wpsb_pkg::REG_MAX_SORPTION: rate_reg        <= cfg_data[RATE_W-1:0];
                wpsb_pkg::REG_HALF_SAT:     half_sat_reg    <= cfg_data[CONC_W-1:0];
                default:                    ;
            endcase
        end
    end

    // pipeline control
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg     <= {valid_reg[S_F-1:0], in_valid};
            out_valid_reg <= valid_reg[S_F];
        end
    end

    // capture and suspended solids products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vol_reg      <= water_volume;
            share_reg[0] <= forest_fraction;
            share_reg[1] <= grass_fraction;
            share_reg[2] <= crop_fraction;
            cprod_reg[0] <= share_reg[0] * conc_forest_reg;
            cprod_reg[1] <= share_reg[1] * conc_grass_reg;
            cprod_reg[2] <= share_reg[2] * conc_crop_reg;
        end
    end

    wpsb_mul #(.AW(W), .BW(RATE_W), .LAT(LM)) u_mul_vr (
        .clk (clk),
        .en  (en),
        .a   (vol_reg),
        .b   (rate_reg),
        .p   (vr_prod)
    );

    wpsb_mul #(.AW(CONC_W), .BW(W), .LAT(LM)) u_mul_kv (
        .clk (clk),
        .en  (en),
        .a   (half_sat_reg),
        .b   (vol_reg),
        .p   (kv_prod)
    );

    wpsb_mul #(.AW(VR_W), .BW(CS_W), .LAT(LM)) u_mul_sb (
        .clk (clk),
        .en  (en),
        .a   (vr_prod),
        .b   (side_reg[LM].cs),
        .p   (sb_prod)
    );

    wpsb_mul #(.AW(P_W), .BW(P_W), .LAT(LM)) u_mul_bb (
        .clk (clk),
        .en  (en),
        .a   (side_reg[S_P].b),
        .b   (side_reg[S_P].b),
        .p   (bb_prod)
    );

    wpsb_mul #(.AW(KV_W), .BW(TOT_W), .LAT(LM)) u_mul_kt (
        .clk (clk),
        .en  (en),
        .a   (side_reg[S_P].kv),
        .b   (side_reg[S_P].tot),
        .p   (kt_prod)
    );

    // discriminant b*b + 4*kv*total
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= D_W'(bb_prod) + (D_W'(kt_prod) << 2);
        end
    end

    wpsb_sqrt #(.DW(D_W), .RW(RW)) u_sqrt (
        .clk  (clk),
        .en   (en),
        .d    (d_reg),
        .root (root)
    );

    // sideband stage logic
    always_comb
    begin
        logic [P_W-1:0] tot_ext;
        logic [RW:0]    sum_br;
        logic [RW:0]    diff_rb;
        side_t          s;

        s         = '0;
        s.fp      = free_phosphate;
        s.bp      = bound_phosphate;
        s.tot     = TOT_W'(free_phosphate) + TOT_W'(bound_phosphate);
        s.skip    = water_volume == '0;
        side_next[0] = s;
        tot_ext   = '0;
        sum_br    = '0;
        diff_rb   = '0;

        for (int k = 1; k <= S_F; k++)
        begin
            s = side_reg[k-1];
            if (k == S_CS)
            begin
                s.cs = CS_W'(cprod_reg[0]) + CS_W'(cprod_reg[1]) + CS_W'(cprod_reg[2]);
            end
            if (k == S_KV)
            begin
                s.kv = kv_prod[KV_PW-1:wpsb_pkg::CONC_BITS];
            end
            if (k == S_PA)
            begin
                s.p = P_W'(sb_prod[SB_PW-1:SB_SH]) + P_W'(s.kv);
            end
            if (k == S_P)
            begin
                tot_ext = P_W'(s.tot);
                if (tot_ext >= s.p)
                begin
                    s.b   = tot_ext - s.p;
                    s.neg = 1'b0;
                end
                else
                begin
                    s.b   = s.p - tot_ext;
                    s.neg = 1'b1;
                end
            end
            if (k == S_F)
            begin
                sum_br  = (RW+1)'(s.b) + (RW+1)'(root);
                diff_rb = (RW+1)'(root) - (RW+1)'(s.b);
                if (!s.neg)
                begin
                    s.f = sum_br[RW:1];
                end
                else if (diff_rb[RW])
                begin
                    s.f = '0;
                end
                else
                begin
                    s.f = diff_rb[RW:1];
                end
            end
            side_next[k] = s;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k <= S_F; k++)
            begin
                side_reg[k] <= side_next[k];
            end
        end
    end

    // clamp to total and saturate; skipped cells pass their inputs through
    always_comb
    begin
        f_clamp = (side_reg[S_F].f > RW'(side_reg[S_F].tot)) ? side_reg[S_F].tot
                                                             : side_reg[S_F].f[TOT_W-1:0];
        g_val   = side_reg[S_F].tot - f_clamp;
        if (side_reg[S_F].skip)
        begin
            free_out  = side_reg[S_F].fp;
            bound_out = side_reg[S_F].bp;
        end
        else
        begin
            free_out  = f_clamp[W] ? '1 : f_clamp[W-1:0];
            bound_out = g_val[W] ? '1 : g_val[W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            new_free_reg  <= free_out;
            new_bound_reg <= bound_out;
            skipped_reg   <= side_reg[S_F].skip;
        end
    end

    assign out_valid           = out_valid_reg;
    assign new_free_phosphate  = new_free_reg;
    assign new_bound_phosphate = new_bound_reg;
    assign skipped             = skipped_reg;

endmodule

/* rtl/core/wpsb_mul.sv */
// pipelined multiplier built from 32x32 partial products and a registered adder tree
module wpsb_mul #(
    parameter int AW  = 32,
    parameter int BW  = 32,
    parameter int LAT = 3
) (
    input  logic          clk,
    input  logic          en,
    input  logic [AW-1:0] a,
    input  logic [BW-1:0] b,
    output logic [AW+BW-1:0] p
);

    localparam int LW  = wpsb_pkg::LIMB_W;
    localparam int LA  = wpsb_pkg::limbs(AW);
    localparam int LB  = wpsb_pkg::limbs(BW);
    localparam int NP  = LA * LB;
    localparam int LEV = $clog2(NP);
    localparam int NL  = 1 << LEV;
    localparam int PW  = AW + BW;
    localparam int EW  = LW * (LA + LB);
    localparam int PAD = LAT - 1 - LEV;

    logic [LW*LA-1:0] a_ext;
    logic [LW*LB-1:0] b_ext;
    logic [PW-1:0]    tree_reg [1:2*NL-1];

    assign a_ext = (LW*LA)'(a);
    assign b_ext = (LW*LB)'(b);

    for (genvar k = 0; k < NL; k++) begin : g_leaf
        if (k < NP) begin : g_pp
            localparam int LI = k / LB;
            localparam int LJ = k % LB;
            logic [2*LW-1:0] pp;
            logic [EW-1:0]   ps;
            assign pp = a_ext[LI*LW +: LW] * b_ext[LJ*LW +: LW];
            assign ps = EW'(pp) << (LW * (LI + LJ));
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    tree_reg[NL+k] <= ps[PW-1:0];
                end
            end
        end else begin : g_zero
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    tree_reg[NL+k] <= '0;
                end
            end
        end
    end

    for (genvar n = 1; n < NL; n++) begin : g_node
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                tree_reg[n] <= tree_reg[2*n] + tree_reg[2*n+1];
            end
        end
    end

    if (PAD > 0) begin : g_pad
        logic [PW-1:0] pad_reg [0:PAD-1];
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pad_reg[0] <= tree_reg[1];
                for (int i = 1; i < PAD; i++)
                begin
                    pad_reg[i] <= pad_reg[i-1];
                end
            end
        end
        assign p = pad_reg[PAD-1];
    end else begin : g_nopad
        assign p = tree_reg[1];
    end

endmodule

/* rtl/core/wpsb_sqrt.sv */
// pipelined integer square root, one root bit per stage
module wpsb_sqrt #(
    parameter int DW = 139,
    parameter int RW = 70
) (
    input  logic          clk,
    input  logic          en,
    input  logic [DW-1:0] d,
    output logic [RW-1:0] root
);

    logic [RW-1:0]   rem_reg  [0:RW-1];
    logic [RW-1:0]   q_reg    [0:RW-1];
    logic [2*RW-1:0] dat_reg  [0:RW-1];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic [RW-1:0]   rin;
        logic [RW-1:0]   qin;
        logic [2*RW-1:0] din;
        logic [RW+1:0]   shifted;
        logic [RW+1:0]   trial;
        logic [RW+1:0]   rem_next;
        logic            ge;

        if (k == 0) begin : g_first
            assign rin = '0;
            assign qin = '0;
            assign din = (2*RW)'(d);
        end else begin : g_rest
            assign rin = rem_reg[k-1];
            assign qin = q_reg[k-1];
            assign din = dat_reg[k-1];
        end

        assign shifted  = {rin, din[2*RW-1 -: 2]};
        assign trial    = {qin, 2'b01};
        assign ge       = shifted >= trial;
        assign rem_next = ge ? (shifted - trial) : shifted;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next[RW-1:0];
                q_reg[k]   <= {qin[RW-2:0], ge};
                dat_reg[k] <= din << 2;
            end
        end
    end

    assign root = q_reg[RW-1];

endmodule

/* test/tb.sv */
// testbench for the phosphate sorption balance pipeline: queued stimulus, bit-exact predictor
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int W = wpsb_pkg::VALUE_WIDTH_DEF;
    localparam int SHARE_W = wpsb_pkg::SHARE_W;
    localparam int WATCHDOG_LIMIT = 3000;

    typedef logic [255:0] acc_t;

    typedef struct packed {
        logic [W-1:0]       volume;
        logic [W-1:0]       free_p;
        logic [W-1:0]       bound_p;
        logic [SHARE_W-1:0] forest;
        logic [SHARE_W-1:0] grass;
        logic [SHARE_W-1:0] crop;
    } cell_t;

    typedef struct packed {
        logic [W-1:0] free_p;
        logic [W-1:0] bound_p;
        logic         skip;
    } balance_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [wpsb_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [wpsb_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [W-1:0] water_volume = '0;
    logic [W-1:0] free_phosphate = '0;
    logic [W-1:0] bound_phosphate = '0;
    logic [SHARE_W-1:0] forest_fraction = '0;
    logic [SHARE_W-1:0] grass_fraction = '0;
    logic [SHARE_W-1:0] crop_fraction = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [W-1:0] new_free_phosphate;
    logic [W-1:0] new_bound_phosphate;
    logic skipped;

    water_phosphate_sorption_balance #(.VALUE_WIDTH(W)) DUT (.*);

    always #6 clk = ~clk;

    logic [31:0] conc_forest = '0;
    logic [31:0] conc_grass = '0;
    logic [31:0] conc_crop = '0;
    logic [24:0] sorption_rate = '0;
    logic [31:0] half_sat = '0;

    cell_t pending_cells[$];
    balance_t expected_balances[$];
    int errors = 0;
    int cells_sent = 0;
    int balances_checked = 0;
    int skips_seen = 0;
    int settings_run = 0;

    function automatic acc_t floor_sqrt(acc_t d);
        acc_t r;
        r = '0;
        for (int i = 127; i >= 0; i--)
        begin
            r[i] = 1'b1;
            if (r * r > d)
                r[i] = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [W-1:0] saturate(acc_t a);
        if (a[255:W] != '0)
            return {W{1'b1}};
        return a[W-1:0];
    endfunction

    function automatic balance_t sorption_equilibrium(cell_t c);
        balance_t res;
        acc_t cs, tot, sorb, kv, p, b, d, r, f;
        logic neg;
        if (c.volume == '0)
        begin
            res.free_p = c.free_p;
            res.bound_p = c.bound_p;
            res.skip = 1'b1;
            return res;
        end
        cs = acc_t'(c.forest) * acc_t'(conc_forest) + acc_t'(c.grass) * acc_t'(conc_grass)
            + acc_t'(c.crop) * acc_t'(conc_crop);
        tot = acc_t'(c.free_p) + acc_t'(c.bound_p);
        sorb = (cs * acc_t'(c.volume) * acc_t'(sorption_rate))
            >> (wpsb_pkg::SHARE_BITS + wpsb_pkg::CONC_BITS + wpsb_pkg::RATE_BITS);
        kv = (acc_t'(half_sat) * acc_t'(c.volume)) >> wpsb_pkg::CONC_BITS;
        p = sorb + kv;
        neg = (tot < p);
        b = neg ? p - tot : tot - p;
        d = b * b + kv * tot * acc_t'(4);
        r = floor_sqrt(d);
        if (!neg)
            f = (b + r) >> 1;
        else if (r >= b)
            f = (r - b) >> 1;
        else
            f = '0;
        if (f > tot)
            f = tot;
        res.free_p = saturate(f);
        res.bound_p = saturate(tot - f);
        res.skip = 1'b0;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [W-1:0] got, logic [W-1:0] want);
        errors++;
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    endtask

    // driver: bursts with random gaps
    int burst_left = 1;
    int gap_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        cell_t c;
        logic nv;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!(in_valid && !in_ready))
        begin
            nv = 1'b0;
            if (gap_left > 0)
                gap_left--;
            else if (pending_cells.size() > 0)
            begin
                c = pending_cells.pop_front();
                nv = 1'b1;
                water_volume <= c.volume;
                free_phosphate <= c.free_p;
                bound_phosphate <= c.bound_p;
                forest_fraction <= c.forest;
                grass_fraction <= c.grass;
                crop_fraction <= c.crop;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
                end
            end
            in_valid <= nv;
        end
    end

    // receiver stall pattern
    int rx_cycle = 0;
    always @(posedge clk)
    begin
        int mode;
        rx_cycle++;
        mode = (rx_cycle / 317) % 4;
        case (mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 1) == 1);
            2: out_ready <= (rx_cycle % 8 == 0);
            default: out_ready <= (rx_cycle % 16 < 10);
        endcase
    end

    // monitor: predict on input transaction, check on output transaction
    int idle_cycles = 0;
    always @(posedge clk)
    begin
        cell_t c;
        balance_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                c.volume = water_volume;
                c.free_p = free_phosphate;
                c.bound_p = bound_phosphate;
                c.forest = forest_fraction;
                c.grass = grass_fraction;
                c.crop = crop_fraction;
                expected_balances.push_back(sorption_equilibrium(c));
                cells_sent++;
            end
            if (out_valid && out_ready)
            begin
                if (expected_balances.size() == 0)
                begin
                    errors++;
                    $display("unexpected output transaction at %0t", $realtime);
                end
                else
                begin
                    want = expected_balances.pop_front();
                    balances_checked++;
                    if (want.skip)
                        skips_seen++;
                    if (new_free_phosphate !== want.free_p)
                        report_mismatch("new_free_phosphate", new_free_phosphate, want.free_p);
                    if (new_bound_phosphate !== want.bound_p)
                        report_mismatch("new_bound_phosphate", new_bound_phosphate, want.bound_p);
                    if (skipped !== want.skip)
                        report_mismatch("skipped", W'(skipped), W'(want.skip));
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("water_phosphate_sorption_balance verification failed");
                $finish;
            end
        end
    end

    task automatic write_reg(wpsb_pkg::cfg_reg_t idx, logic [31:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            wpsb_pkg::REG_SUSP_FOREST:  conc_forest = value;
            wpsb_pkg::REG_SUSP_GRASS:   conc_grass = value;
            wpsb_pkg::REG_SUSP_CROP:    conc_crop = value;
            wpsb_pkg::REG_MAX_SORPTION: sorption_rate = value[24:0];
            default:                    half_sat = value;
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_all(logic [31:0] f, logic [31:0] g, logic [31:0] c, logic [31:0] rate,
                           logic [31:0] k);
        write_reg(wpsb_pkg::REG_SUSP_FOREST, f);
        write_reg(wpsb_pkg::REG_SUSP_GRASS, g);
        write_reg(wpsb_pkg::REG_SUSP_CROP, c);
        write_reg(wpsb_pkg::REG_MAX_SORPTION, rate);
        write_reg(wpsb_pkg::REG_HALF_SAT, k);
        settings_run++;
    endtask

    // sampled away from the active edge so driver updates have settled
    task automatic drain;
        while (pending_cells.size() > 0 || in_valid || expected_balances.size() > 0)
            @(negedge clk);
    endtask

    function automatic logic [W-1:0] rand_amount();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return W'(v) >> $urandom_range(0, W - 1);
    endfunction

    function automatic logic [SHARE_W-1:0] rand_share();
        if ($urandom_range(0, 9) == 0)
            return SHARE_W'($urandom_range(0, 131071));
        return SHARE_W'($urandom_range(0, 65536));
    endfunction

    function automatic logic [31:0] rand_conc();
        return $urandom >> $urandom_range(0, 31);
    endfunction

    task automatic push_cell(logic [W-1:0] v, logic [W-1:0] fp, logic [W-1:0] bp,
                             logic [SHARE_W-1:0] f, logic [SHARE_W-1:0] g,
                             logic [SHARE_W-1:0] c);
        cell_t x;
        x.volume = v;
        x.free_p = fp;
        x.bound_p = bp;
        x.forest = f;
        x.grass = g;
        x.crop = c;
        pending_cells.push_back(x);
    endtask

    task automatic push_random(int n);
        logic [W-1:0] v;
        for (int i = 0; i < n; i++)
        begin
            v = ($urandom_range(0, 19) == 0) ? '0 : rand_amount();
            if (v == '0 && $urandom_range(0, 1) == 0)
                v = W'(1);
            push_cell(v, rand_amount(), rand_amount(), rand_share(), rand_share(),
                      rand_share());
        end
    endtask

    localparam logic [W-1:0] ONES = {W{1'b1}};
    localparam logic [W-1:0] ONE_Q = W'(65536);

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset configuration, then directed corner cells
        push_cell('0, ONES, ONES, 17'h1ffff, 17'h1ffff, 17'h1ffff);
        push_cell('0, '0, '0, '0, '0, '0);
        push_cell(ONE_Q, ONE_Q, '0, 17'd65536, '0, '0);
        push_cell(ONES, ONES, ONES, '0, '0, '0);
        drain();

        set_all(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'h01000000, 32'hffffffff);
        push_cell(ONES, ONES, ONES, 17'h1ffff, 17'h1ffff, 17'h1ffff);
        push_cell(W'(1), W'(1), '0, 17'd65536, '0, '0);
        push_cell(W'(1), '0, '0, '0, '0, '0);
        push_cell('0, W'(12345), W'(678), 17'd65536, 17'd65536, 17'd65536);
        push_cell(ONE_Q, ONES, '0, '0, 17'd65536, '0);
        push_cell(ONES, W'(1), W'(1), '0, '0, 17'd65536);
        push_cell(ONE_Q, ONE_Q, ONE_Q, 17'd21845, 17'd21845, 17'd21846);
        drain();

        set_all(32'h00010000, 32'h00020000, 32'h00040000, 32'h00800000, 32'h00010000);
        push_cell(ONE_Q, ONE_Q * 10, ONE_Q * 5, 17'd32768, 17'd16384, 17'd16384);
        push_cell(ONE_Q * 1000, ONE_Q, '0, 17'd65536, '0, '0);
        push_cell(W'(1), ONES, ONES, 17'd65536, 17'd65536, 17'd65536);
        push_cell(ONES, '0, '0, 17'd65536, '0, '0);
        push_random(280);
        drain();

        set_all(32'h1, 32'h0, 32'h1, 32'h1, 32'h1);
        push_random(250);
        drain();

        for (int s = 0; s < 5; s++)
        begin
            set_all(rand_conc(), rand_conc(), rand_conc(),
                    $urandom_range(0, 1) ? $urandom_range(0, 16777216) : 32'h01000000,
                    rand_conc());
            push_random(260);
            drain();
        end

        set_all('0, '0, '0, '0, '0);
        push_random(40);
        drain();

        repeat (200) @(posedge clk);
        $display("covered %0d cells (%0d skipped) over %0d register settings",
                 cells_sent, skips_seen, settings_run);
        $display("checked %0d results, %0d mismatches", balances_checked, errors);
        if (errors == 0 && expected_balances.size() == 0)
            $display("water_phosphate_sorption_balance verification clean");
        else
            $display("water_phosphate_sorption_balance verification failed");
        $finish;
    end

endmodule
